>>> sv/lfd_pkg.sv
package lfd_pkg;

	localparam int TICK_COUNT_BITS_DEF = 32;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_LIDAR = 8'h4C;
	localparam logic [7:0] CH_TICK  = 8'h54;

	localparam int FRAME_BYTES = 11;
	localparam logic [3:0] PAYLOAD_BYTES = 4'(FRAME_BYTES - 2);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_OPCODE  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_LIDAR = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_WARN  = 2'd3;

	localparam int TDATA_BITS = 112;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [7:0]  strength;
		logic [31:0] distance_bits;
		logic [31:0] angle_bits;
		logic [31:0] tick_count;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> sv/lfd_parse.sv
module lfd_parse #(
	parameter int TICK_COUNT_BITS = lfd_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    data_byte,
	output logic          res_valid,
	output lfd_pkg::res_t res
);

	logic [1:0]                 phase_q, phase_nxt;
	logic [3:0]                 pos_q, pos_nxt;
	logic [7:0]                 strength_q, strength_nxt;
	logic [63:0]                shift_q, shift_nxt;
	logic [TICK_COUNT_BITS-1:0] cnt_q, cnt_nxt;
	logic [63:0]                cnt_wide;
	logic [2:0]                 lane;

	assign lane     = 3'(pos_q - 4'd1);
	assign cnt_wide = 64'(cnt_nxt);

	always_comb begin
		phase_nxt    = phase_q;
		pos_nxt      = pos_q;
		strength_nxt = strength_q;
		shift_nxt    = shift_q;
		cnt_nxt      = cnt_q;
		res_valid    = 1'b0;
		res          = '0;
		if (fire) begin
			unique case (phase_q)
				lfd_pkg::PH_OPCODE: begin
					if (data_byte == lfd_pkg::CH_TICK) begin
						cnt_nxt        = cnt_q + 1'b1;
						phase_nxt      = lfd_pkg::PH_IDLE;
						res_valid      = 1'b1;
						res.kind       = lfd_pkg::KIND_TICK;
						res.tick_count = cnt_wide[31:0];
					end else if (data_byte == lfd_pkg::CH_LIDAR) begin
						phase_nxt    = lfd_pkg::PH_PAYLOAD;
						pos_nxt      = '0;
						strength_nxt = '0;
						shift_nxt    = '0;
					end else begin
						phase_nxt      = lfd_pkg::PH_IDLE;
						res_valid      = 1'b1;
						res.kind       = lfd_pkg::KIND_WARN;
						res.byte_value = data_byte;
					end
				end
				lfd_pkg::PH_PAYLOAD: begin
					if (pos_q == 4'd0) begin
						strength_nxt = data_byte;
						pos_nxt      = 4'd1;
					end else if (pos_q >= lfd_pkg::PAYLOAD_BYTES) begin
						// out-of-range position: drop the frame
						phase_nxt = lfd_pkg::PH_IDLE;
						pos_nxt   = '0;
					end else begin
						shift_nxt[{lane, 3'b000} +: 8] = data_byte;
						pos_nxt = pos_q + 4'd1;
						if (pos_nxt == lfd_pkg::PAYLOAD_BYTES) begin
							res_valid         = 1'b1;
							res.kind          = lfd_pkg::KIND_LIDAR;
							res.strength      = strength_q;
							res.distance_bits = shift_nxt[31:0];
							res.angle_bits    = shift_nxt[63:32];
							phase_nxt         = lfd_pkg::PH_IDLE;
							pos_nxt           = '0;
						end
					end
				end
				default: begin
					phase_nxt = lfd_pkg::PH_IDLE;
					if (data_byte == lfd_pkg::CH_START) begin
						phase_nxt = lfd_pkg::PH_OPCODE;
					end else begin
						res_valid      = 1'b1;
						res.kind       = lfd_pkg::KIND_PLAIN;
						res.byte_value = data_byte;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lfd_pkg::PH_IDLE;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_nxt;
			pos_q   <= pos_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		strength_q <= strength_nxt;
		shift_q    <= shift_nxt;
	end

endmodule

>>> sv/lfd_res_q.sv
module lfd_res_q (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lfd_pkg::res_t    push_res,
	input  logic             pop,
	output lfd_pkg::res_t    head,
	output lfd_pkg::q_stat_t stat
);

	lfd_pkg::res_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/lidar_frame_deframer_unit.sv
// Serial deframer: one byte per transfer on s_axis, at most one result per byte on m_axis.
// A byte is taken every cycle while m_axis keeps up; the result of a byte reaches m_axis
// through the input register and then a two-entry result queue, which also lets the
// input keep going while m_axis stalls until the queue is full. tuser gives the kind: 0 plain
// byte, 1 lidar record, 2 timing tick, 3 bad opcode. Unused fields of a result read zero.
module lidar_frame_deframer_unit #(
	parameter int TICK_COUNT_BITS = lfd_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // data_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// byte_value, strength, distance_bits, angle_bits, tick_count
	output logic [lfd_pkg::TDATA_BITS-1:0] m_axis_tdata,
	output logic [1:0]                     m_axis_tuser   // kind
);

	logic             in_valid_s1;
	logic [7:0]       byte_s1;
	logic             fire;
	logic             res_valid;
	lfd_pkg::res_t    res;
	lfd_pkg::res_t    head;
	lfd_pkg::q_stat_t q_stat;
	logic             pop;

	assign fire          = in_valid_s1 && !q_stat.full;
	assign s_axis_tready = !in_valid_s1 || !q_stat.full;
	assign m_axis_tvalid = !q_stat.empty;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	lfd_parse #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	lfd_res_q u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	assign m_axis_tuser = head.kind;
	assign m_axis_tdata = {head.tick_count, head.angle_bits, head.distance_bits,
		head.strength, head.byte_value};

`ifndef SYNTHESIS
	a_res_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> fire)
		else $error("result without a consumed byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> in_valid_s1 && q_stat.full)
		else $error("input stalled without a full queue");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !pop |=> q_stat.full && !res_valid)
		else $error("queue lost an entry or took one while full");

	a_lidar_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == lfd_pkg::KIND_LIDAR |-> res.byte_value == 8'd0 &&
		res.tick_count == 32'd0)
		else $error("lidar record carries stray fields");
`endif

endmodule
